// ----- design/pxv_pkg.sv -----
// Shared types, constants and the ID decode for the pixel ID plurality vote block.
package pxv_pkg;

    localparam int MAX_OBJECTS_DEF = 256;
    localparam int PIX_W           = 32;
    localparam int CFG_W           = 9;
    localparam int CNT_W           = 9;
    localparam int OBJ_OUT_W       = 8;
    localparam int RES_TDATA_W     = 24;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic vote;
        logic last;
    } t_pix_ctl;

    typedef struct packed {
        logic                 found;
        logic [OBJ_OUT_W-1:0] object_index;
        logic [CNT_W-1:0]     vote_count;
    } t_result;

    // Rotate right by 8 so the low byte lands on top, then drop one (ID zero is background).
    function automatic logic [PIX_W-1:0] decode_id(input logic [PIX_W-1:0] w);
        return {w[7:0], w[PIX_W-1:8]} - PIX_W'(1);
    endfunction

endpackage

// ----- design/pxv_decode.sv -----
// Pixel decode: ID extraction and range check against the object count.
module pxv_decode
    import pxv_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    parameter int IDX_W       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
    input  logic [PIX_W-1:0] i_pixel_word,
    input  logic             i_last_pixel,
    input  logic [CFG_W-1:0] i_object_count,
    output logic [IDX_W-1:0] o_id,
    output t_pix_ctl         o_ctl
);

    logic [PIX_W-1:0] id_full;

    always_comb begin
        id_full    = decode_id(i_pixel_word);
        o_id       = id_full[IDX_W-1:0];
        o_ctl.last = i_last_pixel;
        // Clamp the count to capacity by testing both limits.
        o_ctl.vote = (id_full < PIX_W'(i_object_count)) && (id_full < PIX_W'(MAX_OBJECTS));
    end

endmodule

// ----- design/pxv_vote.sv -----
// Vote stage: per-object counter memory, read-modify-write with bypass, running winner.
module pxv_vote
    import pxv_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    parameter int IDX_W       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IDX_W-1:0] i_id,
    input  t_pix_ctl         i_ctl,
    input  logic             i_res_ready,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [CNT_W-1:0]       r_mem [MAX_OBJECTS];
    logic [MAX_OBJECTS-1:0] r_seen;
    logic [CNT_W-1:0]       r_rd;
    logic                   r_fwd;
    logic [CNT_W-1:0]       r_fwd_cnt;
    logic                   r_a_vld;
    logic [IDX_W-1:0]       r_a_id;
    t_pix_ctl               r_a_ctl;
    logic [CNT_W-1:0]       r_best_cnt;
    logic [IDX_W-1:0]       r_best_obj;
    logic                   r_have;

    logic             a_stall;
    logic             a_fire;
    logic             accept;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] inc_cnt;
    logic             do_inc;
    logic             win;
    logic [CNT_W-1:0] n_best_cnt;
    logic [IDX_W-1:0] n_best_obj;
    logic             n_have;

    always_comb begin
        a_stall = r_a_vld && r_a_ctl.last && !i_res_ready;
        o_ready = !a_stall;
        accept  = i_valid && o_ready;
        a_fire  = r_a_vld && !a_stall;

        // Take the bypassed count when the previous pixel just wrote this entry.
        if (r_fwd) begin
            cur_cnt = r_fwd_cnt;
        end else if (r_seen[r_a_id]) begin
            cur_cnt = r_rd;
        end else begin
            cur_cnt = '0;
        end
        do_inc  = r_a_ctl.vote && (cur_cnt != COUNT_MAX);
        inc_cnt = cur_cnt + CNT_W'(1);
        win     = do_inc && (!r_have || (inc_cnt > r_best_cnt));

        n_best_cnt = win ? inc_cnt : r_best_cnt;
        n_best_obj = win ? r_a_id  : r_best_obj;
        n_have     = win || r_have;

        o_res_valid        = a_fire && r_a_ctl.last;
        o_res.found        = n_have;
        o_res.object_index = n_have ? OBJ_OUT_W'(n_best_obj) : '0;
        o_res.vote_count   = n_have ? n_best_cnt : '0;
    end

    // Counter memory: write on increment, registered read on transfer.
    always_ff @(posedge i_clk) begin
        if (a_fire && do_inc) begin
            r_mem[r_a_id] <= inc_cnt;
        end
        if (accept) begin
            r_rd      <= r_mem[i_id];
            r_fwd_cnt <= inc_cnt;
            r_a_id    <= i_id;
            r_a_ctl   <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_fwd      <= 1'b0;
            r_seen     <= '0;
            r_best_cnt <= '0;
            r_best_obj <= '0;
            r_have     <= 1'b0;
        end else begin
            if (accept) begin
                r_a_vld <= 1'b1;
                r_fwd   <= a_fire && do_inc && !r_a_ctl.last && (i_id == r_a_id);
            end else if (a_fire) begin
                r_a_vld <= 1'b0;
                r_fwd   <= 1'b0;
            end

            if (a_fire) begin
                if (r_a_ctl.last) begin
                    // Window done: drop all counts and the winner.
                    r_seen     <= '0;
                    r_best_cnt <= '0;
                    r_best_obj <= '0;
                    r_have     <= 1'b0;
                end else begin
                    if (do_inc) begin
                        r_seen[r_a_id] <= 1'b1;
                    end
                    r_best_cnt <= n_best_cnt;
                    r_best_obj <= n_best_obj;
                    r_have     <= n_have;
                end
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_a_ctl.last) |=> (!r_have && r_best_cnt == '0 && r_seen == '0))
        else $error("window state not cleared after last pixel");

    a_winner_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have == (r_best_cnt != '0))
        else $error("winner flag disagrees with best count");

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_a_vld)
        else $error("bypass armed with no pixel in stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_stall |=> (r_a_vld && r_a_ctl.last && $stable(r_a_id)))
        else $error("stalled last pixel lost");

endmodule

// ----- design/pixel_id_plurality_vote.sv -----
// Top level: stream ports, object count register and result output register.
// Throughput: one pixel per cycle; only a last pixel waits, while the previous result is held.
// A last pixel is registered in the vote stage, together with its counter memory read, and its result
// is then registered in the result register that drives m_axis; a held result stalls it in the vote stage.
// Reset (i_rst_n low, synchronous): object count goes to 0, counts read as zero at once
// through per-entry valid bits, no winner held; no clearing pass is needed.
module pixel_id_plurality_vote
    import pxv_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,   // pixel_word
    input  logic                   s_axis_tlast,   // last_pixel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [RES_TDATA_W-1:0] m_axis_tdata,   // found, object_index[8:1], vote_count[17:9]
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    logic [CFG_W-1:0] r_object_count;
    logic             r_o_vld;
    t_result          r_o_res;

    logic [IDX_W-1:0] dec_id;
    t_pix_ctl         dec_ctl;
    logic             res_ready;
    logic             res_valid;
    t_result          res;

    pxv_decode #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .IDX_W       (IDX_W)
    ) u_decode (
        .i_pixel_word   (s_axis_tdata),
        .i_last_pixel   (s_axis_tlast),
        .i_object_count (r_object_count),
        .o_id           (dec_id),
        .o_ctl          (dec_ctl)
    );

    pxv_vote #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .IDX_W       (IDX_W)
    ) u_vote (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_id        (dec_id),
        .i_ctl       (dec_ctl),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign res_ready     = !r_o_vld || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {(RES_TDATA_W - CNT_W - OBJ_OUT_W - 1)'(0),
                            r_o_res.vote_count, r_o_res.object_index, r_o_res.found};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_object_count <= '0;
            r_o_vld        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_object_count <= i_cfg_data;
            end
            if (res_valid) begin
                r_o_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Result payload: load on the last pixel, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_o_res <= res;
        end
    end

endmodule

// ----- tb/pixel_id_plurality_vote_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the pixel ID plurality vote block: directed and random windows, checked per result.
module pixel_id_plurality_vote_tb
    import pxv_pkg::*;
();

    localparam int OBJ_SLOTS     = 256;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 700;
    localparam int DRAIN_CYCLES  = 10;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIX_W-1:0]       s_axis_tdata  = '0;    // pixel_word
    logic                   s_axis_tlast  = 1'b0;  // last_pixel
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [RES_TDATA_W-1:0] m_axis_tdata;          // found, object_index[8:1], vote_count[17:9]
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data    = '0;

    // Vote tally mirror and the queue of window results still owed by the block
    logic [CNT_W-1:0]     tally [OBJ_SLOTS];
    logic [CNT_W-1:0]     lead_count;
    logic [OBJ_OUT_W-1:0] lead_object;
    bit                   have_lead;
    logic [CFG_W-1:0]     cfg_objects;
    t_result              winner_q [$];
    t_result              want;

    int fail_count   = 0;
    int idle_cycles  = 0;
    int tx_gap_max   = 12;
    int rx_stall_max = 12;
    int rx_wait      = 0;
    int rx_draw      = 0;
    int focus_base   = 0;

    pixel_id_plurality_vote dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_window();
        foreach (tally[k]) tally[k] = '0;
        lead_count  = '0;
        lead_object = '0;
        have_lead   = 1'b0;
    endfunction

    // Tally one pixel; returns 1 with the window result when the pixel closes the window.
    function automatic bit tally_pixel(input logic [PIX_W-1:0] word, input bit last,
                                       output t_result res);
        logic [31:0]      id;
        logic [31:0]      lim;
        logic [CNT_W-1:0] c;
        lim = (cfg_objects > CFG_W'(OBJ_SLOTS)) ? 32'(OBJ_SLOTS) : 32'(cfg_objects);
        id  = {word[7:0], word[31:8]} - 32'd1;
        res = '0;
        if (id < lim) begin
            c = tally[id[7:0]];
            if (c != COUNT_MAX) begin
                c = c + CNT_W'(1);
                tally[id[7:0]] = c;
                // strictly larger only: the object that got there first keeps a tie
                if (!have_lead || c > lead_count) begin
                    lead_count  = c;
                    lead_object = id[7:0];
                    have_lead   = 1'b1;
                end
            end
        end
        if (!last) return 1'b0;
        if (have_lead) begin
            res.found        = 1'b1;
            res.object_index = lead_object;
            res.vote_count   = lead_count;
        end
        clear_window();
        return 1'b1;
    endfunction

    // Encode an object index the way the ID buffer stores it; index -1 gives background.
    function automatic logic [PIX_W-1:0] word_for(input int obj);
        logic [31:0] id;
        id = obj + 1;
        return {id[23:0], id[31:24]};
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        int r;
        int lim;
        r   = $urandom_range(0, 99);
        lim = (cfg_objects > CFG_W'(OBJ_SLOTS)) ? OBJ_SLOTS : int'(cfg_objects);
        if (r < 60) return word_for(focus_base + $urandom_range(0, 5));
        if (r < 75) return word_for($urandom_range(0, OBJ_SLOTS - 1));
        if (r < 85) return word_for(lim - 1 + $urandom_range(0, 2));
        if (r < 90) return '0;
        return $urandom;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] word, input bit last);
        int      gap;
        t_result res;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (tally_pixel(word, last, res)) winner_q = {winner_q, res};
    endtask

    // Write the object count only once every owed result is back and the pipe has drained.
    task automatic write_object_count(input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (winner_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_objects = value;
    endtask

    task automatic test_zero_count();
        // nothing written yet: count is zero, so no pixel votes
        send_pixel(word_for(0), 1'b0);
        send_pixel(word_for(5), 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(word_for(1), 1'b1);
    endtask

    task automatic test_field_extremes();
        write_object_count(CFG_W'(OBJ_SLOTS));
        send_pixel(word_for(0), 1'b0);
        send_pixel(word_for(255), 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(word_for(256), 1'b0);
        send_pixel(word_for(255), 1'b1);
        send_pixel(word_for(0), 1'b1);
        send_pixel('0, 1'b1);
    endtask

    task automatic test_tie_break();
        write_object_count(CFG_W'(10));
        send_pixel(word_for(3), 1'b0);
        send_pixel(word_for(7), 1'b0);
        send_pixel(word_for(7), 1'b0);
        send_pixel(word_for(3), 1'b0);
        send_pixel(word_for(9), 1'b0);
        send_pixel(word_for(10), 1'b1);
    endtask

    task automatic test_count_clamp();
        write_object_count('1);
        send_pixel(word_for(255), 1'b0);
        send_pixel(word_for(256), 1'b1);
        write_object_count(CFG_W'(257));
        send_pixel(word_for(256), 1'b0);
        send_pixel(word_for(200), 1'b1);
        write_object_count(CFG_W'(1));
        send_pixel(word_for(1), 1'b0);
        send_pixel(word_for(0), 1'b1);
    endtask

    task automatic test_saturation();
        write_object_count(CFG_W'(2));
        tx_gap_max = 0;
        for (int i = 0; i < 520; i++) send_pixel(word_for(1), 1'b0);
        send_pixel(word_for(0), 1'b0);
        send_pixel(word_for(1), 1'b1);
        tx_gap_max = 12;
    endtask

    task automatic test_random_windows();
        int               sent;
        int               len;
        logic [CFG_W-1:0] cfg;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 7))
                    0:       cfg = '0;
                    1:       cfg = CFG_W'(1);
                    2:       cfg = CFG_W'(255);
                    3:       cfg = CFG_W'(OBJ_SLOTS);
                    4:       cfg = '1;
                    5:       cfg = CFG_W'($urandom_range(257, 510));
                    default: cfg = CFG_W'($urandom_range(2, 254));
                endcase
                write_object_count(cfg);
            end
            tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 12;
            rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            focus_base   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 250);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) send_pixel(random_pixel(), i == len - 1);
            sent += len;
        end
    endtask

    // Result side: after each transfer, hold ready low for a random number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = $urandom_range(0, rx_stall_max);
            rx_wait       <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            rx_wait       <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (winner_q.size() == 0) begin
                $error("result with no window pending: tdata=%h", m_axis_tdata);
                fail_count++;
            end else begin
                want = winner_q.pop_front();
                if (m_axis_tdata[0] !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[8:1] !== want.object_index) begin
                    $error("object_index: expected %0d, actual %0d",
                           want.object_index, m_axis_tdata[8:1]);
                    fail_count++;
                end
                if (m_axis_tdata[17:9] !== want.vote_count) begin
                    $error("vote_count: expected %0d, actual %0d",
                           want.vote_count, m_axis_tdata[17:9]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        cfg_objects = '0;
        clear_window();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_count();
        test_field_extremes();
        test_tie_break();
        test_count_clamp();
        test_saturation();
        test_random_windows();

        s_axis_tvalid <= 1'b0;
        while (winner_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && winner_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/pxv_pkg.sv
design/pxv_decode.sv
design/pxv_vote.sv
design/pixel_id_plurality_vote.sv
tb/pixel_id_plurality_vote_tb.sv
